/* sv/slnu_pkg.sv */
// Shared constants, field layout and unit interface types of the loop normalizer.
package slnu_pkg;

    localparam int MAX_DIMS  = 7;
    localparam int DIM_W     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    localparam int IDX_W     = 32;
    localparam int STEP_W    = 31;
    localparam int COUNT_W   = 33;
    localparam int WORD_W    = 64;
    localparam int KEPT_W    = 3;
    localparam int FIRST_W   = 32;

    // The narrow multiplier operand is a magnitude of up to 2^32.
    localparam int SMALL_W   = 33;
    localparam int PROD_W    = WORD_W + SMALL_W;
    localparam int MUL_STEPS = SMALL_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
    localparam int DIV_STEPS = COUNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int S_TDATA_W = 160;
    localparam int M_TDATA_W = 168;

    // Result tdata layout.
    localparam int OUT_COUNT_LSB  = 0;
    localparam int OUT_STRIDE_LSB = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_OFFSET_LSB = OUT_STRIDE_LSB + WORD_W;
    localparam int OUT_KEPT_LSB   = OUT_OFFSET_LSB + WORD_W;
    localparam int OUT_OVF_BIT    = OUT_KEPT_LSB + KEPT_W;

    localparam logic KIND_LOOP    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                start;
        logic [WORD_W-1:0]   big;
        logic [SMALL_W-1:0]  small_mag;
        logic                small_neg;
    } mul_req_t;

    typedef struct packed {
        logic                done;
        logic [WORD_W-1:0]   prod;
        logic                ovf;
    } mul_rsp_t;

    typedef struct packed {
        logic                start;
        logic [COUNT_W-1:0]  dividend;
        logic [STEP_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [COUNT_W-1:0]  quot;
    } div_rsp_t;

endpackage

/* sv/strided_subarray_loop_normalizer_unit.sv */
// Strided sub-array loop normalizer: one dimension per input transaction, flat loops out.
//
// Each input transaction describes one dimension of a strided view, first dimension first,
// with tlast on the last one (the seventh dimension always ends the descriptor). The block
// emits a loop entry for every dimension whose count is not one and, after the last
// dimension, a summary (tuser high, tlast high) with the start offset and the number of kept
// loops, preceded by a count-one loop entry if no loop was kept. All products go through one
// shared shift-add multiplier that retires one bit per cycle. Each dimension runs the stride
// and offset multiplies and an add; an inner dimension then emits its loop entry, if any,
// and scales the running multiplier by the extent, while the last dimension writes its
// results. Each result also waits
// while the output register still holds an earlier one. The count divider runs alongside
// the first multiply. s_axis_tready is high only between dimensions; a result waiting in
// the output register holds up the block only once the next result is ready to be written.
module strided_subarray_loop_normalizer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // base_begin[31:0], base_end[63:32], view_begin[95:64], view_end[127:96],
    // step[158:128], zero pad[159]
    input  logic [slnu_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,   // final_dim
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // loop_count[32:0], loop_stride[96:33], start_offset[160:97], kept_loops[163:161],
    // overflow[164], zero pad[167:165]
    output logic [slnu_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,   // kind
    output logic                           m_axis_tlast    // last
);
    import slnu_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MUL_STR  = 9'b000000010,
        ST_MUL_OFF  = 9'b000000100,
        ST_ADD      = 9'b000001000,
        ST_DECIDE   = 9'b000010000,
        ST_LOOP_OUT = 9'b000100000,
        ST_FILL_OUT = 9'b001000000,
        ST_SUM_OUT  = 9'b010000000,
        ST_MUL_RM   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Descriptor state.
    logic [WORD_W-1:0]  rmul_reg, rmul_next;
    logic [WORD_W-1:0]  offs_reg, offs_next;
    logic [KEPT_W-1:0]  kept_reg, kept_next;
    logic [DIM_W-1:0]   dim_reg, dim_next;
    logic [FIRST_W-1:0] first_reg, first_next;
    logic               ovf_reg, ovf_next;

    // Per-dimension working registers.
    logic               fin_reg, fin_next;
    logic               dneg_reg, dneg_next;
    logic [SMALL_W-1:0] omag_reg, omag_next;
    logic               oneg_reg, oneg_next;
    logic [SMALL_W-1:0] emag_reg, emag_next;
    logic               eneg_reg, eneg_next;
    logic [WORD_W-1:0]  stride_reg, stride_next;
    logic [WORD_W-1:0]  oprod_reg, oprod_next;

    // Output register.
    logic               ov_reg, ov_next;
    logic               okind_reg, okind_next;
    logic [COUNT_W-1:0] ocnt_reg, ocnt_next;
    logic [WORD_W-1:0]  ostr_reg, ostr_next;
    logic [WORD_W-1:0]  ooff_reg, ooff_next;
    logic [KEPT_W-1:0]  okept_reg, okept_next;
    logic               oovf_reg, oovf_next;
    logic               olast_reg, olast_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               s_accept;
    logic               out_free;
    logic               post;
    logic [STEP_W-1:0]  st_in;
    logic [IDX_W:0]     diff_in;
    logic [IDX_W:0]     off_in;
    logic [IDX_W+1:0]   ext_in;
    logic [IDX_W+1:0]   ext_abs;
    logic [IDX_W:0]     dmag_in;
    logic [WORD_W-1:0]  add_sum;

    logic [IDX_W-1:0]   bb_in, be_in, vb_in, ve_in;

    assign bb_in = s_axis_tdata[31:0];
    assign be_in = s_axis_tdata[63:32];
    assign vb_in = s_axis_tdata[95:64];
    assign ve_in = s_axis_tdata[127:96];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;

    // A zero step counts as one.
    assign st_in   = (s_axis_tdata[158:128] == '0) ? STEP_W'(1) : s_axis_tdata[158:128];
    assign diff_in = {ve_in[IDX_W-1], ve_in} - {vb_in[IDX_W-1], vb_in};
    assign dmag_in = diff_in[IDX_W] ? (~diff_in + 1'b1) : diff_in;
    assign off_in  = {vb_in[IDX_W-1], vb_in} - {bb_in[IDX_W-1], bb_in};
    assign ext_in  = {{2{be_in[IDX_W-1]}}, be_in} - {{2{bb_in[IDX_W-1]}}, bb_in}
                     + (IDX_W+2)'(1);
    assign ext_abs = ext_in[IDX_W+1] ? (~ext_in + 1'b1) : ext_in;
    assign add_sum = offs_reg + oprod_reg;

    always_comb begin
        state_next  = state_reg;
        rmul_next   = rmul_reg;
        offs_next   = offs_reg;
        kept_next   = kept_reg;
        dim_next    = dim_reg;
        first_next  = first_reg;
        ovf_next    = ovf_reg;
        fin_next    = fin_reg;
        dneg_next   = dneg_reg;
        omag_next   = omag_reg;
        oneg_next   = oneg_reg;
        emag_next   = emag_reg;
        eneg_next   = eneg_reg;
        stride_next = stride_reg;
        oprod_next  = oprod_reg;
        ov_next     = ov_reg && !m_axis_tready;
        okind_next  = okind_reg;
        ocnt_next   = ocnt_reg;
        ostr_next   = ostr_reg;
        ooff_next   = ooff_reg;
        okept_next  = okept_reg;
        oovf_next   = oovf_reg;
        olast_next  = olast_reg;
        post        = 1'b0;

        mul_req.start     = 1'b0;
        mul_req.big       = rmul_reg;
        mul_req.small_mag = {2'b00, st_in};
        mul_req.small_neg = 1'b0;
        div_req.start     = 1'b0;
        div_req.dividend  = dmag_in;
        div_req.divisor   = st_in;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    fin_next      = s_axis_tlast || (dim_reg == DIM_W'(MAX_DIMS - 1));
                    dneg_next     = diff_in[IDX_W];
                    oneg_next     = off_in[IDX_W];
                    omag_next     = off_in[IDX_W] ? (~off_in + 1'b1) : off_in;
                    eneg_next     = ext_in[IDX_W+1];
                    emag_next     = ext_abs[SMALL_W-1:0];
                    if (dim_reg == '0) begin
                        first_next = {1'b0, st_in};
                    end
                    div_req.start = 1'b1;
                    mul_req.start = 1'b1;
                    state_next    = ST_MUL_STR;
                end
            end
            ST_MUL_STR: begin
                mul_req.small_mag = omag_reg;
                mul_req.small_neg = oneg_reg;
                if (mul_rsp.done) begin
                    stride_next   = mul_rsp.prod;
                    ovf_next      = ovf_reg | mul_rsp.ovf;
                    mul_req.start = 1'b1;
                    state_next    = ST_MUL_OFF;
                end
            end
            ST_MUL_OFF: begin
                if (mul_rsp.done) begin
                    oprod_next = mul_rsp.prod;
                    ovf_next   = ovf_reg | mul_rsp.ovf;
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                offs_next = add_sum;
                if ((offs_reg[WORD_W-1] == oprod_reg[WORD_W-1]) &&
                    (add_sum[WORD_W-1] != offs_reg[WORD_W-1])) begin
                    ovf_next = 1'b1;
                end
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // The count is one exactly when the truncated quotient is zero.
                if (div_rsp.done) begin
                    if (div_rsp.quot != '0) begin
                        state_next = ST_LOOP_OUT;
                    end else begin
                        post = 1'b1;
                    end
                end
            end
            ST_LOOP_OUT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = KIND_LOOP;
                    // A reversed view that spans at least one step is kept as empty.
                    ocnt_next  = dneg_reg ? '0 : (div_rsp.quot + 1'b1);
                    ostr_next  = stride_reg;
                    ooff_next  = '0;
                    okept_next = '0;
                    oovf_next  = ovf_reg;
                    olast_next = 1'b0;
                    kept_next  = kept_reg + 1'b1;
                    post       = 1'b1;
                end
            end
            ST_FILL_OUT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = KIND_LOOP;
                    ocnt_next  = COUNT_W'(1);
                    ostr_next  = {{(WORD_W-FIRST_W){1'b0}}, first_reg};
                    ooff_next  = '0;
                    okept_next = '0;
                    oovf_next  = ovf_reg;
                    olast_next = 1'b0;
                    state_next = ST_SUM_OUT;
                end
            end
            ST_SUM_OUT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    okind_next = KIND_SUMMARY;
                    ocnt_next  = '0;
                    ostr_next  = '0;
                    ooff_next  = offs_reg;
                    okept_next = (kept_reg == '0) ? KEPT_W'(1) : kept_reg;
                    oovf_next  = ovf_reg;
                    olast_next = 1'b1;
                    rmul_next  = WORD_W'(1);
                    offs_next  = '0;
                    kept_next  = '0;
                    dim_next   = '0;
                    first_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_RM: begin
                if (mul_rsp.done) begin
                    rmul_next  = mul_rsp.prod;
                    ovf_next   = ovf_reg | mul_rsp.ovf;
                    dim_next   = dim_reg + 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // After the loop decision: close the descriptor or scale the running multiplier.
        if (post) begin
            if (fin_reg) begin
                state_next = (kept_next == '0) ? ST_FILL_OUT : ST_SUM_OUT;
            end else begin
                mul_req.start     = 1'b1;
                mul_req.small_mag = emag_reg;
                mul_req.small_neg = eneg_reg;
                state_next        = ST_MUL_RM;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rmul_reg  <= WORD_W'(1);
            offs_reg  <= '0;
            kept_reg  <= '0;
            dim_reg   <= '0;
            first_reg <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rmul_reg  <= rmul_next;
            offs_reg  <= offs_next;
            kept_reg  <= kept_next;
            dim_reg   <= dim_next;
            first_reg <= first_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
        fin_reg    <= fin_next;
        dneg_reg   <= dneg_next;
        omag_reg   <= omag_next;
        oneg_reg   <= oneg_next;
        emag_reg   <= emag_next;
        eneg_reg   <= eneg_next;
        stride_reg <= stride_next;
        oprod_reg  <= oprod_next;
        okind_reg  <= okind_next;
        ocnt_reg   <= ocnt_next;
        ostr_reg   <= ostr_next;
        ooff_reg   <= ooff_next;
        okept_reg  <= okept_next;
        oovf_reg   <= oovf_next;
        olast_reg  <= olast_next;
    end

    slnu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    slnu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_OVF_BIT-1){1'b0}}, oovf_reg, okept_reg,
                            ooff_reg, ostr_reg, ocnt_reg};

endmodule

/* sv/slnu_mul.sv */
// Shift-add signed multiplier, one multiplier bit per cycle, with signed 64-bit overflow check.
module slnu_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  slnu_pkg::mul_req_t req,
    output slnu_pkg::mul_rsp_t rsp
);
    import slnu_pkg::*;

    logic [WORD_W-1:0]    mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WORD_W:0]      sum;
    logic [WORD_W-1:0]    low;
    logic [WORD_W-1:0]    limit;

    always_comb begin
        sum       = {1'b0, acc_reg[PROD_W-1:SMALL_W]} + {1'b0, mag_reg};
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start) begin
            mag_next  = req.big[WORD_W-1] ? (~req.big + 1'b1) : req.big;
            neg_next  = req.big[WORD_W-1] ^ req.small_neg;
            acc_next  = {{WORD_W{1'b0}}, req.small_mag};
            cnt_next  = MUL_CNT_W'(MUL_STEPS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            acc_next = {(acc_reg[0] ? sum : {1'b0, acc_reg[PROD_W-1:SMALL_W]}),
                        acc_reg[SMALL_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    // The exact product is a magnitude and a sign; the negative range reaches one further.
    assign low      = acc_reg[WORD_W-1:0];
    assign limit    = neg_reg ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    assign rsp.done = done_reg;
    assign rsp.prod = neg_reg ? (~low + 1'b1) : low;
    assign rsp.ovf  = (|acc_reg[PROD_W-1:WORD_W]) || (low > limit);

endmodule

/* sv/slnu_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module slnu_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  slnu_pkg::div_req_t req,
    output slnu_pkg::div_rsp_t rsp
);
    import slnu_pkg::*;

    logic [STEP_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]    dvs_reg, dvs_next;
    logic [COUNT_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W:0]      shifted;
    logic [STEP_W:0]      trial;
    logic                 ge;

    always_comb begin
        shifted   = {rem_reg, quo_reg[COUNT_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        ge        = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (req.start) begin
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = ge ? trial[STEP_W-1:0] : shifted[STEP_W-1:0];
            quo_next = {quo_reg[COUNT_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

/* sv/slnu_checker.sv */
// Port-level assertions for the loop normalizer, bound to the top level.
module slnu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [slnu_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser,
    input logic                           m_axis_tlast
);
    import slnu_pkg::*;

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Only a summary ends a run.
    a_last_is_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("tlast does not match summary kind");

    // A summary reports at least one kept loop and no loop fields.
    a_summary_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY) |->
            (m_axis_tdata[OUT_OVF_BIT-1:OUT_KEPT_LSB] != '0) &&
            (m_axis_tdata[OUT_OFFSET_LSB-1:0] == '0))
        else $error("malformed summary");

    // A loop entry carries no offset and no kept count.
    a_loop_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == KIND_LOOP) |->
            (m_axis_tdata[OUT_OVF_BIT-1:OUT_OFFSET_LSB] == '0))
        else $error("malformed loop entry");

    // An accepted dimension keeps the input not ready while the block works on it.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input accepted again too soon");

endmodule

bind strided_subarray_loop_normalizer_unit slnu_checker u_slnu_checker (.*);
